[rtl/core/bmhq_pkg.sv]
// Package for the binary min-heap queue: sizes, operation and status codes.
// Used by the channel interfaces and by the heap queue module; bmhq_ram does not use it.
package bmhq_pkg;

  // Number of entries the heap can hold.
  localparam int CAPACITY = 64;

  // Index and count widths follow from the capacity.
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = ADDR_W + 2;

  // Fixed payload widths of the channels.
  localparam int DATA_W      = 32;
  localparam int CNT_FIELD_W = 7;

  // Operation carried by a request.
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  // Outcome reported with each result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[rtl/core/bmhq_if.sv]
// Valid/ready channel interfaces for the heap queue requests and results.
// Depends on bmhq_pkg for payload widths.
interface bmhq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [bmhq_pkg::DATA_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bmhq_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bmhq_pkg::DATA_W-1:0]      popped_value;
  logic signed [bmhq_pkg::DATA_W-1:0]      min_value;
  logic        [bmhq_pkg::CNT_FIELD_W-1:0] count;
  logic        [1:0]                       status;

  modport source (output valid, output popped_value, output min_value, output count,
                  output status, input ready);
  modport sink   (input valid, input popped_value, input min_value, input count,
                  input status, output ready);
endinterface

[rtl/core/bmhq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; width and depth are set by the instantiating module.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/binary_min_heap_queue.sv]
// Binary min-heap priority queue of signed 32-bit values, CAPACITY entries in one RAM.
// Depends on bmhq_pkg, the bmhq_in_if / bmhq_out_if interfaces and bmhq_ram.
//
// Each request is either a push or a pop, and each gives exactly one result with the
// popped value, the new minimum, the new count and a status. The block handles one
// request at a time and is not ready while a sift runs. A push rises level by level
// until it reaches the root or its parent is not larger. A pop sinks level by level
// until no child is smaller or it stops at a node with no children, and a pop that
// empties the heap does not sink at all. The pace is set by the single registered RAM
// read port: each step waits for its read and one comparator decides each step. A
// refused push (full) or a pop on an empty heap raises the result valid at the
// accepting edge itself. A new request is taken only when the result register is
// empty or its result is taken in the same cycle, and a stalled result holds off the
// next request. The store needs no clearing after reset.
module binary_min_heap_queue (
  input  logic       clk,
  input  logic       rst_n,
  bmhq_in_if.sink    in_req,
  bmhq_out_if.source out_rsp
);
  import bmhq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UP_RD  = 9'b000000010,
    S_UP_CMP = 9'b000000100,
    S_POP_LD = 9'b000001000,
    S_DN_RDL = 9'b000010000,
    S_DN_RDR = 9'b000100000,
    S_DN_CMP = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_SPARE  = 9'b100000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [ADDR_W-1:0]          pos_r, pos_nxt;
  logic signed [DATA_W-1:0]   cur_r, cur_nxt;
  logic signed [DATA_W-1:0]   best_val_r, best_val_nxt;
  logic                       best_left_r, best_left_nxt;
  logic                       right_ok_r, right_ok_nxt;
  logic signed [DATA_W-1:0]   popped_r, popped_nxt;
  logic signed [DATA_W-1:0]   root_r;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]   out_popped_r, out_popped_nxt;
  logic signed [DATA_W-1:0]   out_min_r, out_min_nxt;
  logic [CNT_FIELD_W-1:0]     out_count_r, out_count_nxt;
  status_t                    out_status_r, out_status_nxt;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic signed [DATA_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [DATA_W-1:0]          ram_rdata;
  logic signed [DATA_W-1:0]   rd_val;

  logic signed [DATA_W-1:0]   cmp_a, cmp_b;
  logic                       cmp_lt;

  logic                       accept;
  logic                       out_free;
  logic [CHILD_W-1:0]         left_idx, right_idx, n_ext;
  logic [ADDR_W-1:0]          parent_idx;

  // Heap storage.
  bmhq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_val = $signed(ram_rdata);

  // Tree navigation around the current position.
  assign left_idx   = CHILD_W'({pos_r, 1'b1});
  assign right_idx  = CHILD_W'({pos_r, 1'b0}) + CHILD_W'(2);
  assign n_ext      = CHILD_W'(count_r);
  assign parent_idx = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);

  // Handshake.
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == S_IDLE) && out_free;
  assign accept       = in_req.valid && in_req.ready;

  // Shared signed comparator, operands chosen by the sequencer state.
  always_comb begin
    cmp_a = rd_val;
    cmp_b = cur_r;
    if (state_r == S_UP_CMP) begin
      cmp_a = cur_r;
      cmp_b = rd_val;
    end else if (state_r == S_DN_CMP) begin
      cmp_b = best_val_r;
    end
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    best_val_nxt   = best_val_r;
    best_left_nxt  = best_left_r;
    right_ok_nxt   = right_ok_r;
    popped_nxt     = popped_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = cur_r;
    ram_raddr      = ADDR_W'(count_r - CNT_W'(1));
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_popped_nxt = out_popped_r;
    out_min_nxt    = out_min_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.kind == KIND_PUSH) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              // Refused push: report the unchanged heap.
              out_valid_nxt  = 1'b1;
              out_popped_nxt = '0;
              out_min_nxt    = root_r;
              out_count_nxt  = CNT_FIELD_W'(count_r);
              out_status_nxt = ST_FULL;
            end else begin
              cur_nxt    = in_req.value;
              pos_nxt    = ADDR_W'(count_r);
              count_nxt  = count_r + CNT_W'(1);
              popped_nxt = '0;
              state_nxt  = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              // Pop on an empty heap.
              out_valid_nxt  = 1'b1;
              out_popped_nxt = '0;
              out_min_nxt    = '0;
              out_count_nxt  = '0;
              out_status_nxt = ST_EMPTY;
            end else begin
              // The last entry is read now and moves into the root.
              popped_nxt = root_r;
              count_nxt  = count_r - CNT_W'(1);
              state_nxt  = S_POP_LD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          // Parent is larger: move it down into the hole and climb.
          ram_wdata = rd_val;
          pos_nxt   = parent_idx;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_POP_LD: begin
        cur_nxt = rd_val;
        pos_nxt = '0;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_RDL;
        end
      end

      S_DN_RDL: begin
        if (left_idx >= n_ext) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = ADDR_W'(left_idx);
          state_nxt = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        // Left child versus the sinking value; the sinking value wins ties.
        best_left_nxt = cmp_lt;
        best_val_nxt  = cmp_lt ? rd_val : cur_r;
        right_ok_nxt  = right_idx < n_ext;
        ram_raddr     = ADDR_W'(right_idx);
        state_nxt     = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (right_ok_r && cmp_lt) begin
          ram_wdata = rd_val;
          pos_nxt   = ADDR_W'(right_idx);
          state_nxt = S_DN_RDL;
        end else if (best_left_r) begin
          ram_wdata = best_val_r;
          pos_nxt   = ADDR_W'(left_idx);
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_popped_nxt = popped_r;
        out_min_nxt    = (count_r == '0) ? '0 : root_r;
        out_count_nxt  = CNT_FIELD_W'(count_r);
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers; the root mirror follows every write to entry zero.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    best_val_r   <= best_val_nxt;
    best_left_r  <= best_left_nxt;
    right_ok_r   <= right_ok_nxt;
    popped_r     <= popped_nxt;
    out_popped_r <= out_popped_nxt;
    out_min_r    <= out_min_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    if (ram_we && ram_waddr == '0) begin
      root_r <= ram_wdata;
    end
  end

  // Result channel.
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.popped_value = out_popped_r;
  assign out_rsp.min_value    = out_min_r;
  assign out_rsp.count        = out_count_r;
  assign out_rsp.status       = out_status_r;

  // The sequencer holds exactly one state.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state is not one-hot");

  // The entry count never passes the capacity.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every store write lands inside the occupied part of the heap.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) < count_r))
    else $error("heap write outside occupied entries");

  // While a sift runs, no result is pending on the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending during a sift");

  // An empty-pop result reports an empty heap.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> (out_count_r == '0 && out_min_r == '0))
    else $error("empty-pop result reports a non-empty heap");

endmodule

[sim/heap_checker.sv]
// Checker for the binary min-heap queue: keeps its own heap, predicts each result.
// Depends on bmhq_pkg and the bmhq_in_if / bmhq_out_if channel interfaces.
`timescale 1ns / 1ps

module heap_checker (
  input  logic clk,
  input  logic rst_n,
  bmhq_in_if   req_mon,
  bmhq_out_if  rsp_mon,
  output int   mismatches,
  output int   outstanding
);
  import bmhq_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0]      popped;
    logic signed [DATA_W-1:0]      minimum;
    logic        [CNT_FIELD_W-1:0] count;
    status_t                       status;
  } heap_result_t;

  logic signed [DATA_W-1:0] heap_model [CAPACITY];
  int unsigned              entries;
  heap_result_t             pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    entries     = 0;
  end

  // Applies one request to the shadow heap and returns the result it should give.
  function automatic heap_result_t apply_heap_request(input kind_t op,
                                                      input logic signed [DATA_W-1:0] val);
    heap_result_t             res;
    int unsigned              pos;
    int unsigned              parent;
    int unsigned              left;
    int unsigned              right;
    int unsigned              best;
    logic signed [DATA_W-1:0] tmp;
    bit                       done;
    res.popped = '0;
    res.status = ST_OK;
    if (op == KIND_PUSH) begin
      if (entries >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // Append at the end and rise while the parent is strictly larger.
        heap_model[entries] = val;
        pos = entries;
        entries++;
        done = 1'b0;
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_model[parent] <= heap_model[pos]) begin
            done = 1'b1;
          end else begin
            tmp                = heap_model[parent];
            heap_model[parent] = heap_model[pos];
            heap_model[pos]    = tmp;
            pos                = parent;
          end
        end
      end
    end else begin
      if (entries == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // Take the root, move the last entry up and sink it; ties go to the left child.
        res.popped    = heap_model[0];
        heap_model[0] = heap_model[entries-1];
        entries--;
        pos  = 0;
        done = 1'b0;
        while (!done) begin
          left  = 2 * pos + 1;
          right = 2 * pos + 2;
          best  = pos;
          if (left < entries && heap_model[left] < heap_model[best]) best = left;
          if (right < entries && heap_model[right] < heap_model[best]) best = right;
          if (best == pos) begin
            done = 1'b1;
          end else begin
            tmp              = heap_model[best];
            heap_model[best] = heap_model[pos];
            heap_model[pos]  = tmp;
            pos              = best;
          end
        end
      end
    end
    res.minimum = (entries > 0) ? heap_model[0] : '0;
    res.count   = CNT_FIELD_W'(entries);
    return res;
  endfunction

  // Compares one field of a result and reports a difference.
  task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Record each accepted request, then match each accepted result against the oldest one.
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      entries = 0;
      pending_results.delete();
    end else begin
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
        pending_results.insert(pending_results.size(),
                               apply_heap_request(kind_t'(req_mon.kind), req_mon.value));
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0d ns: result with no request outstanding, popped %0d min %0d",
                   $time, rsp_mon.popped_value, rsp_mon.min_value);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("popped_value", want.popped, rsp_mon.popped_value);
          check_field("min_value", want.minimum, rsp_mon.min_value);
          check_field("count", want.count, rsp_mon.count);
          check_field("status", want.status, rsp_mon.status);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

[sim/testbench.sv]
// Top of the heap queue testbench: clock, reset, request stimulus and result stalls.
// Depends on bmhq_pkg, the channel interfaces, binary_min_heap_queue and heap_checker.
`timescale 1ns / 1ps

module testbench;
  import bmhq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL  = 50;

  logic        clk;
  logic        rst_n;
  int          send_gap_pct;
  int          rsp_stall_pct;
  int unsigned cycle_count;
  int          mismatches;
  int          outstanding;

  bmhq_in_if  req_ch ();
  bmhq_out_if rsp_ch ();

  binary_min_heap_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  heap_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort the run if the block stops making progress.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stall at the rate of the current phase.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Sends one request, with a random gap before it; returns at the falling edge after
  // the request is taken, leaving valid high so back-to-back requests need no toggle.
  task automatic send_request(input kind_t op, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= op;
    req_ch.value <= val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // A run of random requests with a given share of pushes; values mix the full range,
  // a narrow band that makes many duplicates, and the ends of the range.
  task automatic random_phase(input int push_pct, input int num_requests);
    logic signed [DATA_W-1:0] val;
    kind_t                    op;
    for (int i = 0; i < num_requests; i++) begin
      case ($urandom_range(3))
        0:       val = int'($urandom_range(15)) - 8;
        1: begin
          case ($urandom_range(3))
            0:       val = 32'sh7fffffff;
            1:       val = 32'sh80000000;
            2:       val = 32'sh7ffffffe;
            default: val = 32'sh80000001;
          endcase
        end
        default: val = $urandom;
      endcase
      op = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
      send_request(op, val);
    end
  endtask

  initial begin
    int push_bias [6];
    push_bias = '{55, 92, 50, 8, 90, 12};

    rst_n         = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.kind   = KIND_PUSH;
    req_ch.value  = '0;
    send_gap_pct  = 0;
    rsp_stall_pct = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: pop on an empty heap, a single entry, range extremes and duplicates.
    send_request(KIND_POP, 32'sh12345678);
    send_request(KIND_PUSH, 32'sh0);
    send_request(KIND_POP, 32'sh0);
    send_request(KIND_POP, -32'sh1);
    send_request(KIND_PUSH, 32'sh7fffffff);
    send_request(KIND_PUSH, 32'sh80000000);
    send_request(KIND_PUSH, -32'sh1);
    send_request(KIND_PUSH, 32'sh1);
    send_request(KIND_PUSH, -32'sh1);
    send_request(KIND_PUSH, 32'sh7fffffff);
    send_request(KIND_PUSH, 32'sh55555555);
    send_request(KIND_PUSH, 32'shaaaaaaaa);
    for (int i = 0; i < 8; i++)
      send_request(KIND_POP, 32'sh0);
    send_request(KIND_POP, 32'sh7fffffff);

    // Random phases; pushes dominate in some so the heap fills up and refuses pushes,
    // pops dominate in others so it drains and answers empty.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_gap_pct = 45; rsp_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  rsp_stall_pct = 45; end
        default: begin send_gap_pct = 13; rsp_stall_pct = 13; end
      endcase
      random_phase(push_bias[phase], 150);
    end

    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[binary_min_heap_queue.f]
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_if.sv
rtl/core/bmhq_ram.sv
rtl/core/binary_min_heap_queue.sv
sim/heap_checker.sv
sim/testbench.sv
